// File: hw/rtl/wtil_pkg.sv
// Package for the wavetable interpolating lookup.
// Holds table geometry, field widths and the item kind codes; used by the top level.
package wtil_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned LenW       = AddrW + 1;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned FracW      = 24;
  localparam int unsigned PhaseW     = 32;
  localparam int unsigned ProdW      = AddrW + FracW;
  localparam int unsigned InDataW    = ((AddrW + SampleW + PhaseW + 7) / 8) * 8;
  localparam int unsigned OutDataW   = ((SampleW + 7) / 8) * 8;
  localparam int unsigned LenReset   = TableDepth;

  typedef enum logic [0:0] {
    KIND_LOAD   = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

endpackage

// File: hw/rtl/wavetable_interpolating_lookup.sv
// Wavetable oscillator with linear interpolation, top level.
// Depends on wtil_pkg and wtil_ram (two copies of the table).
//
// Usage:
//   s_axis carries items: tuser = kind (0 load, 1 lookup), tlast = block end,
//   tdata = load_address, load_sample, phase (lowest bits first).
//   A load writes one table entry and yields no result. A lookup wraps the
//   phase fraction onto table_length-1 segments and interpolates the two
//   neighboring entries; the sample leaves on m_axis with tlast copied.
//   cfg carries table_length; write it only while the block is idle.
// Timing:
//   Four-stage pipeline: index multiply, table read (registered memory
//   read on two table copies), interpolation multiply, output register.
//   One item per cycle is taken as long as the output is drained. A load
//   is visible to a lookup accepted in the next cycle.
// Reset:
//   Pipeline and output valids clear; table_length returns to 4096; table
//   contents are undefined until loaded.
// Stall:
//   When m_axis_tready is low with a result held, the whole pipeline holds
//   and s_axis_tready drops in the same cycle.
module wavetable_interpolating_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg: table_length
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wtil_pkg::LenW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: load_address[11:0], load_sample[27:12], phase[59:28], zero pad
  input  logic [wtil_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: kind[0]
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: sample[15:0]
  output logic [wtil_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int unsigned AddrW   = wtil_pkg::AddrW;
  localparam int unsigned LenW    = wtil_pkg::LenW;
  localparam int unsigned SampleW = wtil_pkg::SampleW;
  localparam int unsigned FracW   = wtil_pkg::FracW;
  localparam int unsigned ProdW   = wtil_pkg::ProdW;
  localparam int unsigned MulW    = SampleW + FracW + 2;
  localparam int unsigned SmpLo   = AddrW;
  localparam int unsigned PhLo    = AddrW + SampleW;

  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] eff_len;
  logic [AddrW-1:0] len_m1;
  logic            en;

  logic               s1_valid_q, s1_lookup_q, s1_last_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic [SampleW-1:0] s1_smp_q;
  logic [ProdW-1:0]   s1_prod_q, s1_prod_d;

  logic               s2_valid_q, s2_last_q;
  logic [FracW-1:0]   s2_f_q;

  logic               s3_valid_q, s3_last_q;
  logic [SampleW-1:0] s3_ua_q;
  logic signed [MulW-1:0] s3_mul_q, s3_mul_d;

  logic               out_valid_q, out_last_q;
  logic [SampleW-1:0] out_smp_q, out_smp_d;

  logic [AddrW-1:0]   rd_idx, rd_nxt;
  logic [LenW-1:0]    nxt_full;
  logic               ram_we;
  logic [SampleW-1:0] ra, rb, ua, ub;
  logic signed [SampleW+1:0] diff;
  logic [MulW-1:0]    acc;
  logic [SampleW-1:0] res;
  logic [FracW-1:0]   in_frac;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  assign len_d = (cfg_valid_i) ? cfg_data_i : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(wtil_pkg::LenReset);
    end else begin
      len_q <= len_d;
    end
  end

  always_comb begin
    eff_len = len_q;
    if (len_q < LenW'(2)) begin
      eff_len = LenW'(2);
    end else if (len_q > LenW'(wtil_pkg::TableDepth)) begin
      eff_len = LenW'(wtil_pkg::TableDepth);
    end
  end
  assign len_m1 = AddrW'(eff_len - LenW'(1));

  // Advance the whole pipeline unless a held result blocks it
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: index multiply
  assign in_frac   = s_axis_tdata[PhLo +: FracW];
  assign s1_prod_d = ProdW'(in_frac) * ProdW'(len_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_lookup_q <= (s_axis_tuser == wtil_pkg::KIND_LOOKUP);
      s1_last_q   <= s_axis_tlast;
      s1_addr_q   <= s_axis_tdata[AddrW-1:0];
      s1_smp_q    <= s_axis_tdata[SmpLo +: SampleW];
      s1_prod_q   <= s1_prod_d;
    end
  end

  // Stage 2: table read or table write
  assign rd_idx   = s1_prod_q[ProdW-1:FracW];
  assign nxt_full = {1'b0, rd_idx} + LenW'(1);
  assign rd_nxt   = (nxt_full >= eff_len) ? '0 : nxt_full[AddrW-1:0];
  assign ram_we   = en && s1_valid_q && !s1_lookup_q;

  wtil_ram #(
    .Width (SampleW),
    .Depth (wtil_pkg::TableDepth)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_smp_q),
    .re_i    (en),
    .raddr_i (rd_idx),
    .rdata_o (ra)
  );

  wtil_ram #(
    .Width (SampleW),
    .Depth (wtil_pkg::TableDepth)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_smp_q),
    .re_i    (en),
    .raddr_i (rd_nxt),
    .rdata_o (rb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q && s1_lookup_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_f_q    <= s1_prod_q[FracW-1:0];
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: interpolation multiply on offset-binary samples
  assign ua       = {~ra[SampleW-1], ra[SampleW-2:0]};
  assign ub       = {~rb[SampleW-1], rb[SampleW-2:0]};
  assign diff     = $signed({2'b00, ub}) - $signed({2'b00, ua});
  assign s3_mul_d = MulW'(diff) * $signed({1'b0, s2_f_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ua_q   <= ua;
      s3_mul_q  <= s3_mul_d;
      s3_last_q <= s2_last_q;
    end
  end

  // Stage 4: accumulate, round half up, back to two's complement
  assign acc = {2'b00, s3_ua_q, FracW'(0)} + MulW'(s3_mul_q)
             + (MulW'(1) << (FracW - 1));
  assign res       = acc[FracW +: SampleW];
  assign out_smp_d = {~res[SampleW-1], res[SampleW-2:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_smp_q  <= out_smp_d;
      out_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = wtil_pkg::OutDataW'(out_smp_q);
  assign m_axis_tlast  = out_last_q;

endmodule

// File: hw/rtl/wtil_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module wtil_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
